// File: rtl/jtl_pkg.sv
package jtl_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;

    localparam logic [2:0] SKIP_FALSE = 3'd4;
    localparam logic [2:0] SKIP_OTHER = 3'd3;

    typedef enum logic [3:0] {
        KIND_LBRACE = 4'd0,
        KIND_RBRACE = 4'd1,
        KIND_LBRACK = 4'd2,
        KIND_RBRACK = 4'd3,
        KIND_COMMA  = 4'd4,
        KIND_COLON  = 4'd5,
        KIND_STRING = 4'd6,
        KIND_NUMBER = 4'd7,
        KIND_BOOL   = 4'd8,
        KIND_NULL   = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_START = 2'd1,
        ERR_TRUNC = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_SKIP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        LIT_FALSE = 2'd0,
        LIT_TRUE  = 2'd1,
        LIT_NULL  = 2'd2,
        LIT_SPARE = 2'd3
    } lit_t;

    typedef struct packed {
        err_t       err;
        logic       btrue;
        logic [7:0] vbyte;
        logic       vvalid;
        logic       done;
        kind_t      kind;
    } res_t;

    typedef struct packed {
        logic last;
        res_t res;
    } entry_t;

    typedef struct packed {
        logic       emit;
        res_t       res;
        mode_t      mode;
        logic [2:0] skip;
        lit_t       lit;
        logic       lit_set;
    } idle_t;

    localparam res_t RES_ZERO = '{err: ERR_NONE, btrue: 1'b0, vbyte: 8'h00,
                                  vvalid: 1'b0, done: 1'b0, kind: KIND_LBRACE};

    function automatic logic is_num_start(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_MINUS);
    endfunction

    function automatic logic is_num_cont(input logic [7:0] b);
        return is_num_start(b) || (b == CH_DOT);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    // Lexing of one byte between tokens; skip/lit are only meaningful with
    // mode MODE_SKIP or lit_set.
    function automatic idle_t lex_idle(input logic [7:0] b, input logic last);
        idle_t r;
        r.emit    = 1'b0;
        r.res     = RES_ZERO;
        r.mode    = MODE_IDLE;
        r.skip    = 3'd0;
        r.lit     = LIT_FALSE;
        r.lit_set = 1'b0;
        case (b)
            CH_LBRACE: begin r.emit = 1'b1; r.res.kind = KIND_LBRACE; r.res.done = 1'b1; end
            CH_RBRACE: begin r.emit = 1'b1; r.res.kind = KIND_RBRACE; r.res.done = 1'b1; end
            CH_LBRACK: begin r.emit = 1'b1; r.res.kind = KIND_LBRACK; r.res.done = 1'b1; end
            CH_RBRACK: begin r.emit = 1'b1; r.res.kind = KIND_RBRACK; r.res.done = 1'b1; end
            CH_COMMA:  begin r.emit = 1'b1; r.res.kind = KIND_COMMA;  r.res.done = 1'b1; end
            CH_COLON:  begin r.emit = 1'b1; r.res.kind = KIND_COLON;  r.res.done = 1'b1; end
            CH_QUOTE: begin
                if (last) begin
                    r.emit     = 1'b1;
                    r.res.kind = KIND_STRING;
                    r.res.err  = ERR_TRUNC;
                end else begin
                    r.mode = MODE_STR;
                end
            end
            CH_F, CH_T, CH_N: begin
                r.emit      = 1'b1;
                r.lit_set   = 1'b1;
                r.lit       = (b == CH_F) ? LIT_FALSE : ((b == CH_T) ? LIT_TRUE : LIT_NULL);
                r.res.kind  = (b == CH_N) ? KIND_NULL : KIND_BOOL;
                r.res.btrue = (b == CH_T);
                r.res.done  = 1'b1;
                if (last) begin
                    r.res.err = ERR_TRUNC;
                end else begin
                    r.skip = (b == CH_F) ? SKIP_FALSE : SKIP_OTHER;
                    r.mode = MODE_SKIP;
                end
            end
            default: begin
                if (is_blank(b)) begin
                    r.emit = 1'b0;
                end else if (is_num_start(b)) begin
                    r.emit       = 1'b1;
                    r.res.kind   = KIND_NUMBER;
                    r.res.vvalid = 1'b1;
                    r.res.vbyte  = b;
                    r.res.done   = last;
                    if (!last) begin
                        r.mode = MODE_NUM;
                    end
                end else begin
                    r.emit     = 1'b1;
                    r.res.kind = KIND_LBRACE;
                    r.res.err  = ERR_START;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/json_token_lexer.sv
// JSON token lexer: takes one text byte per item (tlast marks the final byte
// of a text) and emits zero, one or two token events per byte, the last of
// them with tlast set; whitespace between tokens, a non-final opening quote
// and non-final skipped literal bytes give no event. A new byte is accepted
// every cycle as long as the four-entry result queue has room for two events;
// its events are queued and offered, behind any earlier ones, from the cycle
// after it is accepted. A byte that ends a number and starts another token
// yields two events. There is no start-up delay after reset.
module json_token_lexer import jtl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] token_kind, [4] token_done, [5] value_valid, [13:6] value_byte,
    // [14] bool_true, [16:15] error_code, [23:17] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_result
);

    mode_t            mode_reg,  mode_next;
    logic [2:0]       skip_reg,  skip_next;
    lit_t             lit_reg,   lit_next;
    entry_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    res_t       res0, res1;
    logic [1:0] n_res;
    idle_t      idle;
    logic       s_acc, m_acc;
    logic [1:0] push;
    logic [7:0] b;
    logic       last;

    assign b    = s_axis_tdata;
    assign last = s_axis_tlast;

    always_comb begin
        mode_next = mode_reg;
        skip_next = skip_reg;
        lit_next  = lit_reg;
        res0      = RES_ZERO;
        res1      = RES_ZERO;
        n_res     = 2'd0;
        idle      = lex_idle(b, last);
        case (mode_reg)
            MODE_STR: begin
                res0.kind = KIND_STRING;
                n_res     = 2'd1;
                if (b == CH_QUOTE) begin
                    res0.done = 1'b1;
                    mode_next = MODE_IDLE;
                end else begin
                    res0.vvalid = 1'b1;
                    res0.vbyte  = b;
                    if (last) begin
                        res0.err  = ERR_TRUNC;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_NUM: begin
                res0.kind = KIND_NUMBER;
                if (is_num_cont(b)) begin
                    res0.vvalid = 1'b1;
                    res0.vbyte  = b;
                    res0.done   = last;
                    n_res       = 2'd1;
                end else begin
                    res0.done = 1'b1;
                    res1      = idle.res;
                    n_res     = idle.emit ? 2'd2 : 2'd1;
                    mode_next = idle.mode;
                    if (idle.mode == MODE_SKIP) begin
                        skip_next = idle.skip;
                    end
                    if (idle.lit_set) begin
                        lit_next = idle.lit;
                    end
                end
            end
            MODE_SKIP: begin
                if (skip_reg <= 3'd1) begin
                    skip_next = 3'd0;
                    mode_next = MODE_IDLE;
                end else begin
                    skip_next = skip_reg - 3'd1;
                    if (last) begin
                        res0.kind  = ((lit_reg == LIT_FALSE) || (lit_reg == LIT_TRUE))
                                     ? KIND_BOOL : KIND_NULL;
                        res0.btrue = (lit_reg == LIT_TRUE);
                        res0.err   = ERR_TRUNC;
                        n_res      = 2'd1;
                    end
                end
            end
            default: begin
                res0      = idle.res;
                n_res     = idle.emit ? 2'd1 : 2'd0;
                mode_next = idle.mode;
                if (idle.mode == MODE_SKIP) begin
                    skip_next = idle.skip;
                end
                if (idle.lit_set) begin
                    lit_next = idle.lit;
                end
            end
        endcase
        if (last) begin
            mode_next = MODE_IDLE;
            skip_next = 3'd0;
        end
    end

    assign s_axis_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign m_acc         = m_axis_tvalid && m_axis_tready;
    assign push          = s_acc ? n_res : 2'd0;
    assign count_next    = count_reg + CNT_W'(push) - CNT_W'(m_acc);

    assign m_axis_tdata = {7'd0, fifo_reg[rd_ptr_reg].res};
    assign m_axis_tlast = fifo_reg[rd_ptr_reg].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            skip_reg   <= 3'd0;
            lit_reg    <= LIT_FALSE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_acc) begin
                mode_reg <= mode_next;
                skip_reg <= skip_next;
                lit_reg  <= lit_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push);
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= '{last: (push == 2'd1), res: res0};
        end
        if (push == 2'd2) begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= '{last: 1'b1, res: res1};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_skip_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (skip_reg != 3'd0) == (mode_reg == MODE_SKIP))
        else $error("skip count and mode disagree");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_axis_tlast) |=> (mode_reg == MODE_IDLE))
        else $error("lexer not idle after end of text");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("waiting result item changed");

endmodule
